>>> rtl/core/periodic_handler_timer_table_assert.svh
// Assertion macros shared by the timer table modules.
`ifndef PERIODIC_HANDLER_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_HANDLER_TIMER_TABLE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PHTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer table check failed");

// The condition must hold in the cycle after the trigger.
`define PHTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer table check failed");

`endif

>>> rtl/core/phtt_pkg.sv
// Package with the types, codes and defaults of the periodic handler timer table.
`default_nettype none

package phtt_pkg;

    // Fixed widths of the word fields.
    localparam int MODE_W   = 3;
    localparam int HID_W    = 8;
    localparam int PER_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Defaults for the top level parameters.
    localparam int SLOTS_DEFAULT        = 16;
    localparam int PERIOD_BITS_DEFAULT  = 32;
    localparam int HANDLER_BITS_DEFAULT = 8;

    // Command codes.
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SKIP   = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOFIRE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SKIPPED = 2'd3;

    // Command status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PERIOD = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ROTATE,
        ST_BUBBLE,
        ST_FINISH
    } ctrl_state_t;

    // Operation applied by every slot cell in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_BUBBLE,
        CELL_ADD,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/phtt_cell.sv
// One slot cell of the timer chain: holds a slot and exchanges it with its neighbors.
`default_nettype none

module phtt_cell
    import phtt_pkg::*;
#(
    parameter int PERIOD_BITS  = PERIOD_BITS_DEFAULT,
    parameter int HANDLER_BITS = HANDLER_BITS_DEFAULT
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire cell_ctrl_t          ctrl,
    input  wire                      prv_valid,
    input  wire                      nxt_valid,
    input  wire [HANDLER_BITS-1:0]   nxt_handler,
    input  wire [PERIOD_BITS-1:0]    nxt_period,
    input  wire [PERIOD_BITS-1:0]    nxt_remaining,
    input  wire [HANDLER_BITS-1:0]   new_handler,
    input  wire [PERIOD_BITS-1:0]    new_period,
    output logic                     valid,
    output logic [HANDLER_BITS-1:0]  handler,
    output logic [PERIOD_BITS-1:0]   period,
    output logic [PERIOD_BITS-1:0]   remaining
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [HANDLER_BITS-1:0] handler_reg;
    logic [HANDLER_BITS-1:0] handler_next;
    logic [PERIOD_BITS-1:0]  period_reg;
    logic [PERIOD_BITS-1:0]  period_next;
    logic [PERIOD_BITS-1:0]  remaining_reg;
    logic [PERIOD_BITS-1:0]  remaining_next;

    // Next slot contents for the operation of this cycle.
    always_comb
    begin
        valid_next     = valid_reg;
        handler_next   = handler_reg;
        period_next    = period_reg;
        remaining_next = remaining_reg;
        case (ctrl.op)
            CELL_ROTATE:
            begin
                valid_next     = nxt_valid;
                handler_next   = nxt_handler;
                period_next    = nxt_period;
                remaining_next = nxt_remaining;
            end
            CELL_BUBBLE:
            begin
                // A hole pulls in its right neighbor; the cell behind a hole becomes the hole.
                if (!valid_reg)
                begin
                    valid_next     = nxt_valid;
                    handler_next   = nxt_handler;
                    period_next    = nxt_period;
                    remaining_next = nxt_remaining;
                end
                else if (!prv_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_ADD:
            begin
                // Only the first empty cell takes the new slot.
                if (!valid_reg && prv_valid)
                begin
                    valid_next     = 1'b1;
                    handler_next   = new_handler;
                    period_next    = new_period;
                    remaining_next = new_period;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // The valid flag is control state and is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot payload is only read while the slot is valid.
    always_ff @(posedge clk)
    begin
        handler_reg   <= handler_next;
        period_reg    <= period_next;
        remaining_reg <= remaining_next;
    end

    assign valid     = valid_reg;
    assign handler   = handler_reg;
    assign period    = period_reg;
    assign remaining = remaining_reg;

endmodule

`default_nettype wire

>>> rtl/core/phtt_ctrl.sv
// Sequencer of the timer chain: command decode, head slot processing and result register.
`default_nettype none
`include "periodic_handler_timer_table_assert.svh"

module phtt_ctrl
    import phtt_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEFAULT,
    parameter int PERIOD_BITS  = PERIOD_BITS_DEFAULT,
    parameter int HANDLER_BITS = HANDLER_BITS_DEFAULT
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    // Command channel
    input  wire                      cmd_valid,
    output logic                     cmd_stall,
    input  wire [MODE_W-1:0]         mode,
    input  wire [HID_W-1:0]          handler_id,
    input  wire [PER_W-1:0]          period,
    // Result channel
    output logic                     res_valid,
    input  wire                      res_stall,
    output logic [KIND_W-1:0]        kind,
    output logic [HID_W-1:0]         fired_handler,
    output logic [STATUS_W-1:0]      status,
    output logic                     last,
    // Chain head and tail
    input  wire                      head_valid,
    input  wire [HANDLER_BITS-1:0]   head_handler,
    input  wire [PERIOD_BITS-1:0]    head_period,
    input  wire [PERIOD_BITS-1:0]    head_remaining,
    input  wire                      tail_valid,
    output logic                     fb_valid,
    output logic [HANDLER_BITS-1:0]  fb_handler,
    output logic [PERIOD_BITS-1:0]   fb_period,
    output logic [PERIOD_BITS-1:0]   fb_remaining,
    output logic [HANDLER_BITS-1:0]  new_handler,
    output logic [PERIOD_BITS-1:0]   new_period,
    output cell_ctrl_t               cell_ctrl
);

    localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

    ctrl_state_t             state_reg;
    ctrl_state_t             state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    held_reg;
    logic                    held_next;
    logic [HANDLER_BITS-1:0] held_handler_reg;
    logic [HANDLER_BITS-1:0] held_handler_next;
    logic                    found_reg;
    logic                    found_next;
    logic                    skip_reg;
    logic                    skip_next;
    logic [MODE_W-1:0]       mode_reg;
    logic [HANDLER_BITS-1:0] hid_reg;
    logic [PERIOD_BITS-1:0]  per_reg;

    logic                    out_valid_reg;
    logic [KIND_W-1:0]       out_kind_reg;
    logic [HID_W-1:0]        out_fired_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    push;
    logic [KIND_W-1:0]       push_kind;
    logic [HID_W-1:0]        push_fired;
    logic [STATUS_W-1:0]     push_status;
    logic                    push_last;
    logic                    fire;
    logic                    match;
    logic                    step_blocked;
    logic                    accept;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !res_stall;

    // Head slot checks: a decrement to zero fires, a valid slot with the id matches.
    assign fire  = head_valid && (head_remaining == PERIOD_BITS'(1));
    assign match = head_valid && (head_handler == hid_reg) && !found_reg;

    assign new_handler = hid_reg;
    assign new_period  = per_reg;

    // Next state, chain operation and result push.
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        held_next         = held_reg;
        held_handler_next = held_handler_reg;
        found_next        = found_reg;
        skip_next         = skip_reg;
        cell_ctrl.op      = CELL_HOLD;
        push              = 1'b0;
        push_kind         = KIND_STATUS;
        push_fired        = '0;
        push_status       = STATUS_OK;
        push_last         = 1'b1;
        step_blocked      = 1'b0;
        fb_valid          = head_valid;
        fb_handler        = head_handler;
        fb_period         = head_period;
        fb_remaining      = head_remaining;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cnt_next   = '0;
                held_next  = 1'b0;
                found_next = 1'b0;
                case (mode_reg)
                    MODE_TICK:
                    begin
                        if (skip_reg)
                        begin
                            if (out_free)
                            begin
                                push       = 1'b1;
                                push_kind  = KIND_SKIPPED;
                                skip_next  = 1'b0;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_ROTATE;
                        end
                    end
                    MODE_ADD:
                    begin
                        if (out_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                            if (per_reg == '0)
                            begin
                                push_status = STATUS_BAD_PERIOD;
                            end
                            else if (tail_valid)
                            begin
                                push_status = STATUS_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_ADD;
                            end
                        end
                    end
                    MODE_REMOVE:
                    begin
                        state_next = ST_ROTATE;
                    end
                    MODE_CLEAR:
                    begin
                        if (out_free)
                        begin
                            push         = 1'b1;
                            cell_ctrl.op = CELL_CLEAR;
                            state_next   = ST_IDLE;
                        end
                    end
                    MODE_SKIP:
                    begin
                        if (out_free)
                        begin
                            push       = 1'b1;
                            skip_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            push       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_ROTATE:
            begin
                if (mode_reg == MODE_TICK)
                begin
                    // Count down the head slot and reload it when it fires.
                    if (head_valid)
                    begin
                        fb_remaining = fire ? head_period
                                            : head_remaining - PERIOD_BITS'(1);
                    end
                    // An earlier firing is sent once a later one shows it is not the last.
                    if (fire && held_reg)
                    begin
                        step_blocked = !out_free;
                        push         = out_free;
                        push_kind    = KIND_FIRED;
                        push_fired   = HID_W'(held_handler_reg);
                        push_last    = 1'b0;
                    end
                    if (!step_blocked && fire)
                    begin
                        held_next         = 1'b1;
                        held_handler_next = head_handler;
                    end
                end
                else
                begin
                    // The first matching slot is dropped and leaves a hole behind.
                    fb_valid = head_valid && !match;
                    if (match)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (!step_blocked)
                begin
                    cell_ctrl.op = CELL_ROTATE;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next = '0;
                        if ((mode_reg == MODE_TICK) || !found_next)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_BUBBLE;
                        end
                    end
                end
            end
            ST_BUBBLE:
            begin
                // Move the hole to the tail one cell per cycle.
                cell_ctrl.op = CELL_BUBBLE;
                fb_valid     = 1'b0;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                    if (mode_reg == MODE_TICK)
                    begin
                        if (held_reg)
                        begin
                            push_kind  = KIND_FIRED;
                            push_fired = HID_W'(held_handler_reg);
                        end
                        else
                        begin
                            push_kind = KIND_NOFIRE;
                        end
                    end
                    else
                    begin
                        push_status = found_reg ? STATUS_OK : STATUS_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            held_reg  <= 1'b0;
            found_reg <= 1'b0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
            found_reg <= found_next;
            skip_reg  <= skip_next;
        end
    end

    // Command word and held firing.
    always_ff @(posedge clk)
    begin
        held_handler_reg <= held_handler_next;
        if (accept)
        begin
            mode_reg <= mode;
            hid_reg  <= HANDLER_BITS'(handler_id);
            per_reg  <= PERIOD_BITS'(period);
        end
    end

    // Result register: refilled when empty or when the receiver takes its word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_kind_reg   <= push_kind;
            out_fired_reg  <= push_fired;
            out_status_reg <= push_status;
            out_last_reg   <= push_last;
        end
    end

    assign res_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign fired_handler = out_fired_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

    // A blocked rotation step keeps the sweep position.
    `PHTT_ASSERT_NEXT(a_blocked_step_waits, (state_reg == ST_ROTATE) && step_blocked, (state_reg == ST_ROTATE) && $stable(cnt_reg))
    // The final word of a command returns the sequencer to idle.
    `PHTT_ASSERT_NEXT(a_last_ends_command, push && push_last, state_reg == ST_IDLE)
    // Compaction only follows a remove that found its slot.
    `PHTT_ASSERT_NOW(a_bubble_after_match, state_reg == ST_BUBBLE, found_reg && (mode_reg == MODE_REMOVE))

endmodule

`default_nettype wire

>>> rtl/core/periodic_handler_timer_table.sv
// Top level of the periodic handler timer table: a chain of slot cells and its sequencer.
//
// Usage: commands enter on the cmd channel (mode, handler_id, period) and result words
// leave on the res channel (kind, fired_handler, status, last). A word moves at a rising
// edge where valid is high and stall is low; last marks the final word of a command.
// The slots live in a chain of SLOTS cells. A tick or remove sweeps the whole chain once,
// one cell per cycle through the head of the chain while the sweep is not paused; a
// remove that finds its slot then makes a second pass that moves the freed slot to the
// tail. Add, clear, skip, a skipped tick and unknown codes finish in the execute state
// once the result register is free. A new command is taken once the previous one has
// queued its last word. The first result word of a short command is pushed from the
// execute state after acceptance, and during or after the sweep for tick and remove.
// Reset empties the table and drops a pending skip; no clearing pass is needed.
// A stalled receiver holds the result register; a tick that fires again while a word is
// waiting pauses its sweep until that word is taken, so no word is lost or repeated.
`default_nettype none
`include "periodic_handler_timer_table_assert.svh"

module periodic_handler_timer_table
    import phtt_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEFAULT,
    parameter int PERIOD_BITS  = PERIOD_BITS_DEFAULT,
    parameter int HANDLER_BITS = HANDLER_BITS_DEFAULT
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    input  wire [MODE_W-1:0]     mode,
    input  wire [HID_W-1:0]      handler_id,
    input  wire [PER_W-1:0]      period,
    output logic                 res_valid,
    input  wire                  res_stall,
    output logic [KIND_W-1:0]    kind,
    output logic [HID_W-1:0]     fired_handler,
    output logic [STATUS_W-1:0]  status,
    output logic                 last
);

    logic                    cell_valid     [SLOTS];
    logic [HANDLER_BITS-1:0] cell_handler   [SLOTS];
    logic [PERIOD_BITS-1:0]  cell_period    [SLOTS];
    logic [PERIOD_BITS-1:0]  cell_remaining [SLOTS];

    logic                    fb_valid;
    logic [HANDLER_BITS-1:0] fb_handler;
    logic [PERIOD_BITS-1:0]  fb_period;
    logic [PERIOD_BITS-1:0]  fb_remaining;
    logic [HANDLER_BITS-1:0] new_handler;
    logic [PERIOD_BITS-1:0]  new_period;
    cell_ctrl_t              cell_ctrl;

    // Sequencer with head processing and result register.
    phtt_ctrl #(
        .SLOTS        (SLOTS),
        .PERIOD_BITS  (PERIOD_BITS),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .mode           (mode),
        .handler_id     (handler_id),
        .period         (period),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .kind           (kind),
        .fired_handler  (fired_handler),
        .status         (status),
        .last           (last),
        .head_valid     (cell_valid[0]),
        .head_handler   (cell_handler[0]),
        .head_period    (cell_period[0]),
        .head_remaining (cell_remaining[0]),
        .tail_valid     (cell_valid[SLOTS-1]),
        .fb_valid       (fb_valid),
        .fb_handler     (fb_handler),
        .fb_period      (fb_period),
        .fb_remaining   (fb_remaining),
        .new_handler    (new_handler),
        .new_period     (new_period),
        .cell_ctrl      (cell_ctrl)
    );

    // Chain of slot cells; the tail cell is fed back from the sequencer.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic                    nxt_valid;
        logic [HANDLER_BITS-1:0] nxt_handler;
        logic [PERIOD_BITS-1:0]  nxt_period;
        logic [PERIOD_BITS-1:0]  nxt_remaining;
        logic                    prv_valid;

        if (i == SLOTS - 1)
        begin : g_tail
            assign nxt_valid     = fb_valid;
            assign nxt_handler   = fb_handler;
            assign nxt_period    = fb_period;
            assign nxt_remaining = fb_remaining;
        end
        else
        begin : g_inner
            assign nxt_valid     = cell_valid[i+1];
            assign nxt_handler   = cell_handler[i+1];
            assign nxt_period    = cell_period[i+1];
            assign nxt_remaining = cell_remaining[i+1];
        end

        if (i == 0)
        begin : g_head
            assign prv_valid = 1'b1;
        end
        else
        begin : g_body
            assign prv_valid = cell_valid[i-1];
        end

        phtt_cell #(
            .PERIOD_BITS  (PERIOD_BITS),
            .HANDLER_BITS (HANDLER_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (cell_ctrl),
            .prv_valid     (prv_valid),
            .nxt_valid     (nxt_valid),
            .nxt_handler   (nxt_handler),
            .nxt_period    (nxt_period),
            .nxt_remaining (nxt_remaining),
            .new_handler   (new_handler),
            .new_period    (new_period),
            .valid         (cell_valid[i]),
            .handler       (cell_handler[i]),
            .period        (cell_period[i]),
            .remaining     (cell_remaining[i])
        );
    end

    // Between commands the used slots form an unbroken run from the head.
    for (genvar j = 1; j < SLOTS; j++)
    begin : g_chk
        `PHTT_ASSERT_NOW(a_compact_list, !cmd_stall && cell_valid[j], cell_valid[j-1])
    end

endmodule

`default_nettype wire

>>> test/periodic_handler_timer_table_tb.sv
// Self-checking testbench for the periodic handler timer table, with a predictor and scoreboard.
`default_nettype none

module periodic_handler_timer_table_tb;
    import phtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT  = SLOTS_DEFAULT;
    localparam int HOLD_CYCLES = 250;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 2 * SLOT_COUNT + 8;

    // One result word as the block presents it.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HID_W-1:0]    who;
        logic [STATUS_W-1:0] status;
        logic                last;
    } timer_word_t;

    // Shadow copy of the slot list that predicts the words each command produces.
    class slot_table_tracker;
        bit                 live [SLOT_COUNT];
        logic [HID_W-1:0]   owner [SLOT_COUNT];
        logic [PER_W-1:0]   reload [SLOT_COUNT];
        logic [PER_W-1:0]   remaining [SLOT_COUNT];
        int                 used;
        bit                 skip_armed;
        timer_word_t        pending_words[$];
        int                 errors;
        int                 commands;
        int                 words_seen;
        int                 fires;
        int                 full_rejects;
        int                 misses;
        int                 skipped_ticks;
        int                 peak_used;

        function new();
            errors = 0;
            commands = 0;
            words_seen = 0;
            fires = 0;
            full_rejects = 0;
            misses = 0;
            skipped_ticks = 0;
            peak_used = 0;
            wipe_all();
            skip_armed = 1'b0;
        endfunction

        function void wipe_slot(int i);
            live[i] = 1'b0;
            owner[i] = '0;
            reload[i] = '0;
            remaining[i] = '0;
        endfunction

        function void wipe_all();
            for (int i = 0; i < SLOT_COUNT; i++)
                wipe_slot(i);
            used = 0;
        endfunction

        function void push_word(logic [KIND_W-1:0] k, logic [HID_W-1:0] w,
                                logic [STATUS_W-1:0] s, logic l);
            timer_word_t t;
            t.kind = k;
            t.who = w;
            t.status = s;
            t.last = l;
            pending_words.push_back(t);
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction

        // Apply one accepted command and queue the words it must produce.
        function void note_command(logic [MODE_W-1:0] m, logic [HID_W-1:0] id,
                                   logic [PER_W-1:0] p);
            int  fired_n;
            bit  hit;
            commands++;
            case (m)
                MODE_TICK:
                begin
                    if (skip_armed)
                    begin
                        skip_armed = 1'b0;
                        skipped_ticks++;
                        push_word(KIND_SKIPPED, '0, STATUS_OK, 1'b1);
                    end
                    else
                    begin
                        fired_n = 0;
                        for (int i = 0; i < used; i++)
                        begin
                            if (live[i])
                            begin
                                remaining[i] = remaining[i] - 1'b1;
                                if (remaining[i] == '0)
                                begin
                                    remaining[i] = reload[i];
                                    push_word(KIND_FIRED, owner[i], STATUS_OK, 1'b0);
                                    fired_n++;
                                end
                            end
                        end
                        fires += fired_n;
                        if (fired_n == 0)
                            push_word(KIND_NOFIRE, '0, STATUS_OK, 1'b1);
                        else
                            pending_words[pending_words.size() - 1].last = 1'b1;
                    end
                end
                MODE_ADD:
                begin
                    if (p == '0)
                        push_word(KIND_STATUS, '0, STATUS_BAD_PERIOD, 1'b1);
                    else if (used >= SLOT_COUNT)
                    begin
                        full_rejects++;
                        push_word(KIND_STATUS, '0, STATUS_FULL, 1'b1);
                    end
                    else
                    begin
                        live[used] = 1'b1;
                        owner[used] = id;
                        reload[used] = p;
                        remaining[used] = p;
                        used++;
                        if (used > peak_used)
                            peak_used = used;
                        push_word(KIND_STATUS, '0, STATUS_OK, 1'b1);
                    end
                end
                MODE_REMOVE:
                begin
                    hit = 1'b0;
                    for (int i = 0; i < used; i++)
                    begin
                        if (live[i] && owner[i] == id)
                        begin
                            for (int j = i + 1; j < used; j++)
                            begin
                                live[j - 1] = live[j];
                                owner[j - 1] = owner[j];
                                reload[j - 1] = reload[j];
                                remaining[j - 1] = remaining[j];
                            end
                            used--;
                            wipe_slot(used);
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit)
                        push_word(KIND_STATUS, '0, STATUS_OK, 1'b1);
                    else
                    begin
                        misses++;
                        push_word(KIND_STATUS, '0, STATUS_NOT_FOUND, 1'b1);
                    end
                end
                MODE_CLEAR:
                begin
                    // A pending skip survives the clear.
                    wipe_all();
                    push_word(KIND_STATUS, '0, STATUS_OK, 1'b1);
                end
                MODE_SKIP:
                begin
                    skip_armed = 1'b1;
                    push_word(KIND_STATUS, '0, STATUS_OK, 1'b1);
                end
                default:
                    push_word(KIND_STATUS, '0, STATUS_OK, 1'b1);
            endcase
        endfunction

        // Compare one accepted word with the oldest expected one.
        function void check_word(timer_word_t got);
            timer_word_t want;
            words_seen++;
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got kind %0d id %0d %s %0d %s %0d",
                         $time, got.kind, got.who, "status", got.status, "last", got.last);
                return;
            end
            want = pending_words.pop_front();
            if (got.kind !== want.kind)
            begin
                errors++;
                $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, got.kind);
            end
            if (got.who !== want.who)
            begin
                errors++;
                $display("%0t: fired_handler mismatch, expected %0d, got %0d",
                         $time, want.who, got.who);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch, expected %0d, got %0d", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    logic [MODE_W-1:0]   mode;
    logic [HID_W-1:0]    handler_id;
    logic [PER_W-1:0]    period;
    logic                res_valid;
    logic                res_stall;
    logic [KIND_W-1:0]   kind;
    logic [HID_W-1:0]    fired_handler;
    logic [STATUS_W-1:0] status;
    logic                last;

    slot_table_tracker   tracker;
    bit                  hold_off_req;
    bit                  tail_phase;
    int                  idle_cycles;
    int                  hold_offs_done;
    timer_word_t         seen;

    periodic_handler_timer_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .mode         (mode),
        .handler_id   (handler_id),
        .period       (period),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .kind         (kind),
        .fired_handler(fired_handler),
        .status       (status),
        .last         (last)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both handshakes are sampled here; the watchdog counts cycles with no word moving.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                tracker.note_command(mode, handler_id, period);
            if (res_valid && !res_stall)
            begin
                seen.kind = kind;
                seen.who = fired_handler;
                seen.status = status;
                seen.last = last;
                tracker.check_word(seen);
            end
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("periodic_handler_timer_table test failed");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, a long hold-off on request, none in the tail.
    initial
    begin : receiver
        int burst;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                res_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                res_stall = 1'b0;
                hold_off_req = 1'b0;
                hold_offs_done++;
            end
            else if (tail_phase)
                res_stall = 1'b0;
            else
            begin
                burst = $urandom_range(1, 16);
                res_stall = ($urandom_range(0, 3) == 0);
                repeat (burst - 1) @(negedge clk);
            end
        end
    end

    // Offer one command word, after an optional gap, and hold it until it is taken.
    task automatic send_command(logic [MODE_W-1:0] m, logic [HID_W-1:0] id,
                                logic [PER_W-1:0] p, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid = 1'b1;
        mode = m;
        handler_id = id;
        period = p;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Sender pauses until every expected word has come back.
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap(bit gaps_on);
        if (gaps_on && $urandom_range(0, 5) == 0)
            return $urandom_range(1, 16);
        return 0;
    endfunction

    // Ids mostly from a small pool so that removes hit and duplicates occur.
    function automatic logic [HID_W-1:0] pick_id();
        if ($urandom_range(0, 3) == 0)
            return HID_W'($urandom_range(0, 255));
        return HID_W'($urandom_range(0, 11));
    endfunction

    function automatic logic [PER_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return $urandom;
        return $urandom_range(1, 6);
    endfunction

    // Random command mix, with occasional runs of adds that fill the table.
    task automatic run_random(int count, bit gaps_on);
        int left;
        int r;
        int run;
        left = count;
        while (left > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_command(MODE_TICK, HID_W'($urandom), $urandom, pick_gap(gaps_on));
            else if (r < 60)
                send_command(MODE_ADD, pick_id(), pick_period(), pick_gap(gaps_on));
            else if (r < 74)
                send_command(MODE_REMOVE, pick_id(), $urandom, pick_gap(gaps_on));
            else if (r < 79)
                send_command(MODE_CLEAR, HID_W'($urandom), $urandom, pick_gap(gaps_on));
            else if (r < 87)
                send_command(MODE_SKIP, HID_W'($urandom), $urandom, pick_gap(gaps_on));
            else if (r < 90)
                send_command(MODE_W'($urandom_range(5, 7)), HID_W'($urandom), $urandom,
                             pick_gap(gaps_on));
            else if (r < 97)
            begin
                // Short burst of ticks to make slots fire repeatedly.
                run = $urandom_range(2, 5);
                repeat (run)
                    send_command(MODE_TICK, HID_W'($urandom), $urandom, pick_gap(gaps_on));
                left -= run - 1;
            end
            else
            begin
                run = $urandom_range(4, 17);
                repeat (run)
                    send_command(MODE_ADD, pick_id(), $urandom_range(1, 4), pick_gap(gaps_on));
                left -= run - 1;
            end
            left--;
        end
    endtask

    // Main sequence: reset, directed cases, random phases, back-pressure and a calm tail.
    initial
    begin
        tracker = new();
        hold_off_req = 1'b0;
        tail_phase = 1'b0;
        idle_cycles = 0;
        hold_offs_done = 0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        mode = MODE_TICK;
        handler_id = '0;
        period = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, repeated skip and the skipped tick.
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);
        send_command(MODE_SKIP, HID_W'($urandom), $urandom, 0);
        send_command(MODE_SKIP, HID_W'($urandom), $urandom, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);

        // Zero period, id zero, id at its top, a duplicate id and the largest period.
        send_command(MODE_ADD, 8'h33, '0, 0);
        send_command(MODE_ADD, 8'h00, 32'd1, 0);
        send_command(MODE_ADD, 8'hFF, 32'd2, 0);
        send_command(MODE_ADD, 8'h00, 32'd3, 0);
        send_command(MODE_ADD, 8'hA5, 32'hFFFF_FFFF, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);

        // Remove takes the first duplicate; a missing id is reported.
        send_command(MODE_REMOVE, 8'h00, $urandom, 0);
        send_command(MODE_REMOVE, 8'h77, $urandom, 0);

        // Clear keeps a pending skip.
        send_command(MODE_SKIP, HID_W'($urandom), $urandom, 0);
        send_command(MODE_CLEAR, HID_W'($urandom), $urandom, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);
        send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);

        // Unknown codes.
        send_command(3'd5, HID_W'($urandom), $urandom, 0);
        send_command(3'd7, HID_W'($urandom), $urandom, 0);

        run_random(70, 1'b1);
        wait_drained();

        // Long receiver hold-off while a full table and a run of ticks pile up.
        hold_off_req = 1'b1;
        send_command(MODE_CLEAR, HID_W'($urandom), $urandom, 0);
        repeat (SLOT_COUNT + 1)
            send_command(MODE_ADD, pick_id(), $urandom_range(1, 2), 0);
        repeat (5)
            send_command(MODE_TICK, HID_W'($urandom), $urandom, 0);
        while (hold_off_req)
            @(posedge clk);

        run_random(70, 1'b1);
        wait_drained();

        // Tail with no idling on either side.
        tail_phase = 1'b1;
        run_random(40, 1'b0);
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d commands and %0d result words: %0d fires, %0d skipped ticks,",
                 tracker.commands, tracker.words_seen, tracker.fires, tracker.skipped_ticks);
        $display("%0d full-table rejects, %0d missed removes, peak fill %0d, %0d long hold-offs.",
                 tracker.full_rejects, tracker.misses, tracker.peak_used, hold_offs_done);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("periodic_handler_timer_table test passed");
        else
            $display("periodic_handler_timer_table test failed");
        $finish;
    end

endmodule

`default_nettype wire
